### hdl/ggs_pkg.sv
// ggs_pkg: shared widths, register indexes, reset values and blur kernel
// for the grid gaussian smoother
// no dependencies
package ggs_pkg;

   // field widths of the tile and result channels
   localparam int HARD_W    = 8;
   localparam int ROW_W     = 5;
   localparam int COL_W     = 7;
   localparam int SUM_W     = HARD_W + 4;

   // geometry defaults
   localparam int MAX_COLS_DEF = 128;
   localparam int MAX_ROWS_DEF = 32;

   // control register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_W      = 8;
   localparam int CSR_COLS_W = 8;
   localparam int CSR_ROWS_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COLS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_ROWS = 1'd1;

   localparam logic [CSR_COLS_W-1:0] COLS_RESET = 8'd80;
   localparam logic [CSR_ROWS_W-1:0] ROWS_RESET = 6'd21;

   // 3x3 kernel, upper row first, older column first within a row
   localparam logic [2:0] KERNEL [9] = '{3'd1, 3'd2, 3'd1,
                                         3'd2, 3'd4, 3'd2,
                                         3'd1, 3'd2, 3'd1};

   // weighted sum of the nine window taps
   function automatic logic [SUM_W-1:0] blur_sum(input logic [8:0][HARD_W-1:0] taps);
      logic [SUM_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < 9; k++) begin
         acc = acc + SUM_W'(taps[k]) * SUM_W'(KERNEL[k]);
      end
      return acc;
   endfunction

endpackage

### hdl/grid_gaussian_smoother_top.sv
// grid_gaussian_smoother_top: streaming 3x3 gaussian blur over a bordered tile grid
// depends on ggs_pkg and ggs_ram
//
//   channel  direction  ports                                   transfer when
//   req      in         req_hardness, req_frame_start           req_valid && !req_stall
//   rsp      out        rsp_smoothed, rsp_tile_row/col, last    rsp_valid && !rsp_stall
//   csr      in         csr_index, csr_wdata                    csr_we
//
// one tile per cycle while no result is stalled; the result of an interior tile leaves after
// the transfer of the tile below and right of it, through stage 1 (line ram read), then the output register
// the rate is set by the single line ram: one read and one write per cycle
// reset clears counters, window and control registers; line ram is not cleared
// a stalled result holds the blur stage, which in turn stalls the tile input
module grid_gaussian_smoother_top
   import ggs_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // tile input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [HARD_W-1:0]     req_hardness,
   input  logic                  req_frame_start,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [HARD_W-1:0]     rsp_smoothed,
   output logic [ROW_W-1:0]      rsp_tile_row,
   output logic [COL_W-1:0]      rsp_tile_col,
   output logic                  rsp_last_tile,
   // control registers
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int CW   = $clog2(MAX_COLS);
   localparam int RW   = $clog2(MAX_ROWS);
   localparam int CNW0 = $clog2(MAX_COLS + 1);
   localparam int RNW0 = $clog2(MAX_ROWS + 1);
   localparam int CNW  = (CNW0 > CSR_COLS_W) ? CNW0 : CSR_COLS_W;
   localparam int RNW  = (RNW0 > CSR_ROWS_W) ? RNW0 : CSR_ROWS_W;

   // control registers
   logic [CSR_COLS_W-1:0] cols_ff;
   logic [CSR_ROWS_W-1:0] rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_COLS: cols_ff <= csr_wdata[CSR_COLS_W-1:0];
            CSR_ACTIVE_ROWS: rows_ff <= csr_wdata[CSR_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped geometry
   logic [CNW-1:0] cols_raw, cols_n, cols_last;
   logic [RNW-1:0] rows_raw, rows_n, rows_last;

   always_comb begin
      cols_raw = CNW'(cols_ff);
      rows_raw = RNW'(rows_ff);
      if (cols_raw < CNW'(3)) begin
         cols_n = CNW'(3);
      end else if (cols_raw > CNW'(MAX_COLS)) begin
         cols_n = CNW'(MAX_COLS);
      end else begin
         cols_n = cols_raw;
      end
      if (rows_raw < RNW'(3)) begin
         rows_n = RNW'(3);
      end else if (rows_raw > RNW'(MAX_ROWS)) begin
         rows_n = RNW'(MAX_ROWS);
      end else begin
         rows_n = rows_raw;
      end
      cols_last = cols_n - CNW'(1);
      rows_last = rows_n - RNW'(1);
   end

   // handshake and pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s1_go;
   logic accept;
   logic rsp_valid_ff;

   assign s1_go     = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   // position of the incoming tile
   logic [CW-1:0] col_ff, col_in, col_base, col_cur;
   logic [RW-1:0] row_ff, row_in, row_base, row_cur;
   logic          cur_border, cur_emit, cur_last, cur_wrap;

   always_comb begin
      col_base = req_frame_start ? '0 : col_ff;
      row_base = req_frame_start ? '0 : row_ff;
      col_cur  = (CNW'(col_base) >= cols_n) ? '0 : col_base;
      row_cur  = (RNW'(row_base) >= rows_n) ? '0 : row_base;

      cur_border = (row_cur == '0) || (RNW'(row_cur) == rows_last) ||
                   (col_cur == '0) || (CNW'(col_cur) == cols_last);
      cur_emit   = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
      cur_last   = (RNW'(row_cur) == rows_last) && (CNW'(col_cur) == cols_last);
      cur_wrap   = CNW'(col_cur) >= cols_last;

      if (cur_wrap) begin
         col_in = '0;
         row_in = (RNW'(row_cur) >= rows_last) ? '0 : row_cur + RW'(1);
      end else begin
         col_in = col_cur + CW'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line ram: upper row in the high byte, lower row in the low byte
   logic [2*HARD_W-1:0] ram_rd_data, ram_wr_data;

   // stage 1 holds the tile while its line ram read completes
   logic [CW-1:0]       s1_col_ff;
   logic [RW-1:0]       s1_row_ff;
   logic [HARD_W-1:0]   s1_x_ff;
   logic                s1_emit_ff, s1_last_ff;
   logic                fwd_valid_ff;
   logic [2*HARD_W-1:0] fwd_data_ff;

   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            // write back of the same column in this cycle is bypassed
            fwd_valid_ff <= s1_go && (s1_col_ff == col_cur);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= col_cur;
         s1_row_ff   <= row_cur;
         s1_x_ff     <= cur_border ? '0 : req_hardness;
         s1_emit_ff  <= cur_emit;
         s1_last_ff  <= cur_last;
         fwd_data_ff <= ram_wr_data;
      end
   end

   logic [HARD_W-1:0] up_val, lo_val;

   assign up_val      = fwd_valid_ff ? fwd_data_ff[2*HARD_W-1:HARD_W]
                                     : ram_rd_data[2*HARD_W-1:HARD_W];
   assign lo_val      = fwd_valid_ff ? fwd_data_ff[HARD_W-1:0] : ram_rd_data[HARD_W-1:0];
   assign ram_wr_data = {lo_val, s1_x_ff};

   ggs_ram #(
      .WIDTH (2 * HARD_W),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (ram_rd_data)
   );

   // window: [0..2] column c-1 (up, lo, x), [3..5] column c-2
   logic [HARD_W-1:0] win_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_go) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= up_val;
         win_ff[1] <= lo_val;
         win_ff[2] <= s1_x_ff;
      end
   end

   // blur sum and divide by 16
   logic [8:0][HARD_W-1:0] taps;
   logic [SUM_W-1:0]       sum;
   logic [HARD_W-1:0]      quot;
   logic [RW-1:0]          row_m1;
   logic [CW-1:0]          col_m1;

   always_comb begin
      taps[0] = win_ff[3];
      taps[1] = win_ff[0];
      taps[2] = up_val;
      taps[3] = win_ff[4];
      taps[4] = win_ff[1];
      taps[5] = lo_val;
      taps[6] = win_ff[5];
      taps[7] = win_ff[2];
      taps[8] = s1_x_ff;
      sum     = blur_sum(taps);
      quot    = sum[SUM_W-1:4];
      row_m1  = s1_row_ff - RW'(1);
      col_m1  = s1_col_ff - CW'(1);
   end

   // output register
   logic [HARD_W-1:0] smoothed_ff;
   logic [ROW_W-1:0]  tile_row_ff;
   logic [COL_W-1:0]  tile_col_ff;
   logic              last_tile_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         smoothed_ff  <= (quot == '0) ? HARD_W'(1) : quot;
         tile_row_ff  <= ROW_W'(row_m1);
         tile_col_ff  <= COL_W'(col_m1);
         last_tile_ff <= s1_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_smoothed  = smoothed_ff;
   assign rsp_tile_row  = tile_row_ff;
   assign rsp_tile_col  = tile_col_ff;
   assign rsp_last_tile = last_tile_ff;

   // checks
   a_stall_needs_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled without a blocked blur stage");

   a_result_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> smoothed_ff != '0)
      else $error("result below floor of one");

   a_emit_interior: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_emit_ff |-> s1_row_ff >= RW'(2) && s1_col_ff >= CW'(2))
      else $error("result issued for a tile without a full window");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff &&
         $stable({smoothed_ff, tile_row_ff, tile_col_ff, last_tile_ff}))
      else $error("stalled result dropped");

endmodule

### hdl/ggs_ram.sv
// ggs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ggs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/sv/tb_grid_gaussian_smoother_top.sv
// tb_grid_gaussian_smoother_top: self-checking bench for the streaming 3x3 gaussian smoother
// predicts every blurred tile from the accepted tile stream and checks results in order
// depends on ggs_pkg and grid_gaussian_smoother_top
`timescale 1ns / 100ps

module tb_grid_gaussian_smoother_top
   import ggs_pkg::*;
();

   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_LIMIT   = 4000;
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_REPORTS  = 10;
   localparam int DIR_STEPS    = 25;

   typedef struct packed {
      logic [HARD_W-1:0] smoothed;
      logic [ROW_W-1:0]  tile_row;
      logic [COL_W-1:0]  tile_col;
      logic              last_tile;
   } blur_result_type;

   typedef enum logic [1:0] {STEP_TILE, STEP_CSR} step_kind_type;

   // one row of the directed table: a tile or a register write
   typedef struct packed {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_W-1:0]     value;
      logic                 frame_start;
      logic                 typed;
      blur_result_type      want;
   } dir_step_type;

   typedef enum logic [1:0] {RSP_FREE, RSP_LIGHT, RSP_HEAVY, RSP_PERIODIC} stall_mode_type;

   // bordered 3x3 grids: border tiles must not leak into the sum, a zero sum floors at 1
   localparam dir_step_type DIR_TABLE [DIR_STEPS] = '{
      '{STEP_CSR,  CSR_ACTIVE_COLS, 8'd3,   1'b0, 1'b0, '0},
      '{STEP_CSR,  CSR_ACTIVE_ROWS, 8'd3,   1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b1, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b1, '{8'd63, 5'd1, 7'd1, 1'b1}},
      // out-of-range geometry clamps back to 3x3
      '{STEP_CSR,  CSR_ACTIVE_COLS, 8'd0,   1'b0, 1'b0, '0},
      '{STEP_CSR,  CSR_ACTIVE_ROWS, 8'd2,   1'b0, 1'b0, '0},
      // counters run on without a frame start, then a restart in the middle of a grid
      '{STEP_TILE, '0,              8'd0,   1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd128, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd1,   1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b1, 1'b0, '0},
      '{STEP_TILE, '0,              8'd0,   1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd0,   1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd0,   1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd0,   1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd0,   1'b0, 1'b0, '0},
      '{STEP_TILE, '0,              8'd255, 1'b0, 1'b1, '{8'd1, 5'd1, 7'd1, 1'b1}}
   };

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [HARD_W-1:0]    req_hardness    = '0;
   logic                 req_frame_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [HARD_W-1:0]    rsp_smoothed;
   logic [ROW_W-1:0]     rsp_tile_row;
   logic [COL_W-1:0]     rsp_tile_col;
   logic                 rsp_last_tile;
   logic                 csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [CSR_W-1:0]     csr_wdata       = '0;

   // predicted smoother state
   logic [HARD_W-1:0]     ls_upper [MAX_COLS_DEF];
   logic [HARD_W-1:0]     ls_lower [MAX_COLS_DEF];
   logic [HARD_W-1:0]     win_taps [6];
   int unsigned           row_pos;
   int unsigned           col_pos;
   logic [CSR_COLS_W-1:0] cfg_cols;
   logic [CSR_ROWS_W-1:0] cfg_rows;

   blur_result_type blur_expected_q [$];
   int              blur_mismatches;
   int              results_seen;
   int              burst_left;
   bit              timed_out;

   grid_gaussian_smoother_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_hardness    (req_hardness),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_smoothed    (rsp_smoothed),
      .rsp_tile_row    (rsp_tile_row),
      .rsp_tile_col    (rsp_tile_col),
      .rsp_last_tile   (rsp_last_tile),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned eff_cols(input logic [CSR_COLS_W-1:0] v);
      if (v < 3) return 3;
      if (v > MAX_COLS_DEF) return MAX_COLS_DEF;
      return v;
   endfunction

   function automatic int unsigned eff_rows(input logic [CSR_ROWS_W-1:0] v);
      if (v < 3) return 3;
      if (v > MAX_ROWS_DEF) return MAX_ROWS_DEF;
      return v;
   endfunction

   // advance the predicted smoother by one tile, report whether it yields a result
   function automatic bit predict_blur(input logic [HARD_W-1:0] hardness, input logic fs,
                                       output blur_result_type res);
      int unsigned cols, rows, r, c, x, up, lo, sum;
      bit          hit;
      cols = eff_cols(cfg_cols);
      rows = eff_rows(cfg_rows);
      hit  = 1'b0;
      res  = '0;
      if (fs) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (row_pos >= rows) row_pos = 0;
      if (col_pos >= cols) col_pos = 0;
      r = row_pos;
      c = col_pos;
      // border tiles count as zero
      x  = (r == 0 || r == rows - 1 || c == 0 || c == cols - 1) ? 0 : hardness;
      up = ls_upper[c];
      lo = ls_lower[c];
      if (r >= 2 && c >= 2) begin
         sum = win_taps[3] + 2 * win_taps[4] + win_taps[5]
             + 2 * win_taps[0] + 4 * win_taps[1] + 2 * win_taps[2]
             + up + 2 * lo + x;
         sum = sum / 16;
         if (sum == 0) sum = 1;
         res.smoothed  = HARD_W'(sum);
         res.tile_row  = ROW_W'(r - 1);
         res.tile_col  = COL_W'(c - 1);
         res.last_tile = (r == rows - 1 && c == cols - 1);
         hit = 1'b1;
      end
      win_taps[3] = win_taps[0];
      win_taps[4] = win_taps[1];
      win_taps[5] = win_taps[2];
      win_taps[0] = HARD_W'(up);
      win_taps[1] = HARD_W'(lo);
      win_taps[2] = HARD_W'(x);
      ls_upper[c] = HARD_W'(lo);
      ls_lower[c] = HARD_W'(x);
      if (c >= cols - 1) begin
         col_pos = 0;
         row_pos = (r >= rows - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
      return hit;
   endfunction

   // offer one tile in bursts with random gaps, predict once it transfers
   task automatic feed_tile(input logic [HARD_W-1:0] hardness, input logic fs,
                            input logic typed, input blur_result_type want);
      int              gap;
      blur_result_type res;
      bit              hit;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      req_hardness    <= hardness;
      req_frame_start <= fs;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      hit = predict_blur(hardness, fs, res);
      if (typed) blur_expected_q.push_back(want);
      else if (hit) blur_expected_q.push_back(res);
   endtask

   // lower valid and wait until every predicted result has arrived
   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (blur_expected_q.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ACTIVE_COLS) cfg_cols = data[CSR_COLS_W-1:0];
      else cfg_rows = data[CSR_ROWS_W-1:0];
      @(posedge clock);
   endtask

   // result side: check each transfer, stall on a changing pattern plus one long hold-off
   initial begin : rsp_side
      stall_mode_type  mode;
      int              mode_left;
      int              hold_left;
      bit              hold_done;
      bit              stall_next;
      blur_result_type want;
      mode      = RSP_FREE;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            results_seen++;
            if (blur_expected_q.size() == 0) begin
               blur_mismatches++;
               if (blur_mismatches <= MAX_REPORTS)
                  $display("unexpected result: smoothed=%0d row=%0d col=%0d last=%0d",
                           rsp_smoothed, rsp_tile_row, rsp_tile_col, rsp_last_tile);
            end else begin
               want = blur_expected_q.pop_front();
               if (rsp_smoothed !== want.smoothed || rsp_tile_row !== want.tile_row ||
                   rsp_tile_col !== want.tile_col || rsp_last_tile !== want.last_tile) begin
                  blur_mismatches++;
                  if (blur_mismatches <= MAX_REPORTS)
                     $display({"result mismatch: expected smoothed=%0d row=%0d col=%0d ",
                               "last=%0d, got smoothed=%0d row=%0d col=%0d last=%0d"},
                              want.smoothed, want.tile_row, want.tile_col, want.last_tile,
                              rsp_smoothed, rsp_tile_row, rsp_tile_col, rsp_last_tile);
               end
            end
         end
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(64, 256);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            case (mode)
               RSP_FREE:  stall_next = 1'b0;
               RSP_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
               RSP_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
               default:   stall_next = ((mode_left % 8) < 3);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   initial begin
      // predicted state after reset
      foreach (ls_upper[i]) begin
         ls_upper[i] = '0;
         ls_lower[i] = '0;
      end
      foreach (win_taps[i]) win_taps[i] = '0;
      row_pos         = 0;
      col_pos         = 0;
      cfg_cols        = COLS_RESET;
      cfg_rows        = ROWS_RESET;
      blur_mismatches = 0;
      results_seen    = 0;
      burst_left      = 0;
      timed_out       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         begin : stimulus
            int                    k;
            int                    n;
            int                    phase;
            int                    sent;
            int                    frame_len;
            logic [CSR_COLS_W-1:0] new_cols;
            logic [CSR_W-1:0]      new_rows;
            logic [HARD_W-1:0]     hardness;
            bit                    restart;
            bit                    fs;
            // directed table
            for (k = 0; k < DIR_STEPS; k++) begin
               if (DIR_TABLE[k].kind == STEP_CSR) begin
                  wait_drained(DRAIN_CYCLES);
                  write_csr(DIR_TABLE[k].idx, DIR_TABLE[k].value);
               end else begin
                  feed_tile(DIR_TABLE[k].value, DIR_TABLE[k].frame_start,
                            DIR_TABLE[k].typed, DIR_TABLE[k].want);
               end
            end
            // random phases: extreme geometries first, then small grids
            phase = 0;
            sent  = 0;
            while (sent < RANDOM_ITEMS) begin
               case (phase)
                  0: begin
                     new_cols = 8'd255;
                     new_rows = 8'd0;
                  end
                  1: begin
                     new_cols = 8'd3;
                     new_rows = 8'd32;
                  end
                  2: begin
                     new_cols = 8'd2;
                     new_rows = 8'hff;
                  end
                  default: begin
                     new_cols = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 2))
                                                            : 8'($urandom_range(3, 12));
                     new_rows = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 2))
                                                            : 8'($urandom_range(3, 8));
                  end
               endcase
               // a wider grid must restart, or unwritten line entries would be read
               restart = (phase < 3) || (eff_cols(new_cols) > eff_cols(cfg_cols)) ||
                         ($urandom_range(0, 2) != 0);
               wait_drained(DRAIN_CYCLES);
               write_csr(CSR_ACTIVE_COLS, new_cols);
               write_csr(CSR_ACTIVE_ROWS, new_rows);
               frame_len = eff_cols(cfg_cols) * eff_rows(cfg_rows);
               if (phase < 3) n = frame_len;
               else n = $urandom_range(1, 3) * frame_len +
                        (($urandom_range(0, 3) == 0) ? $urandom_range(1, frame_len - 1) : 0);
               for (k = 0; k < n; k++) begin
                  // sender pause until every result is out
                  if (phase == 1 && k == 48) wait_drained(0);
                  case ($urandom_range(0, 7))
                     0:       hardness = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                     1:       hardness = 8'($urandom_range(0, 5));
                     default: hardness = 8'($urandom_range(0, 255));
                  endcase
                  // mostly well-formed grids, with stray frame starts as noise
                  fs = (k == 0 && restart) ||
                       (phase >= 3 && row_pos == 0 && col_pos == 0 &&
                        $urandom_range(0, 3) != 0) ||
                       (phase >= 3 && $urandom_range(0, 49) == 0);
                  feed_tile(hardness, fs, 1'b0, '0);
               end
               sent += n;
               phase++;
            end
            wait_drained(DRAIN_CYCLES);
         end
         begin : watchdog
            int quiet;
            quiet = 0;
            while (quiet < IDLE_LIMIT) begin
               @(posedge clock);
               if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) quiet = 0;
               else quiet++;
            end
            timed_out = 1'b1;
         end
      join_any
      if (!timed_out && blur_mismatches == 0 && blur_expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
hdl/ggs_pkg.sv
hdl/ggs_ram.sv
hdl/grid_gaussian_smoother_top.sv
tb/sv/tb_grid_gaussian_smoother_top.sv
